[src/ptcr_pkg.sv]
// package: register indexes, threshold modes, default geometry and field widths
`default_nettype none

package ptcr_pkg;

    localparam int FRAME_SIDE_DEFAULT  = 80;
    localparam int GROUP_WIDTH_DEFAULT = 20;

    localparam int COUNT_W  = 16;
    localparam int GAIN_W   = 24;
    localparam int OFFSET_W = 32;
    localparam int DEST_W   = 13;
    localparam int ENERGY_W = 41;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 72;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CALIB_ENABLE     = 2'd0,
        REG_REORDER_ENABLE   = 2'd1,
        REG_THRESHOLD_MODE   = 2'd2,
        REG_GLOBAL_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        THR_NONE      = 2'd0,
        THR_GLOBAL    = 2'd1,
        THR_PER_PIXEL = 2'd2,
        THR_UNUSED    = 2'd3
    } thr_mode_t;

endpackage

`default_nettype wire

[src/pixel_threshold_calibrate_reorder.sv]
// top level: pixel threshold, gain and offset calibration, readout reordering
// The block takes one pixel beat per clock and gives one result beat per pixel through
// registers in turn: an input register holds the sample with its raster index and end-of-frame
// flag, and the result register holds the thresholded count and the calibrated energy from a
// single 17 x 24 bit multiply-add. Raster indexes come from row, column and group counters that
// step with each accepted beat, so the sustained rate is one pixel per clock whenever the
// output side is ready. Configuration is taken at any time through the cfg channel.
`default_nettype none

module pixel_threshold_calibrate_reorder #(
    parameter int FRAME_SIDE  = ptcr_pkg::FRAME_SIDE_DEFAULT,
    parameter int GROUP_WIDTH = ptcr_pkg::GROUP_WIDTH_DEFAULT
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ptcr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [ptcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // pixel_count, pixel_threshold, pixel_gain, pixel_offset
    input  wire  [ptcr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // dest_index, out_count, energy, zero fill
    output logic [ptcr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    import ptcr_pkg::*;

    localparam int FRAME_PIXELS = FRAME_SIDE * FRAME_SIDE;
    localparam int POS_W        = $clog2(FRAME_PIXELS);
    localparam int COL_W        = $clog2(FRAME_SIDE);
    localparam int GROUPS       = FRAME_SIDE / GROUP_WIDTH;
    localparam bit MAP_OK       = (GROUPS != 0) && (GROUPS * GROUP_WIDTH == FRAME_SIDE);
    localparam int GRP_N        = (GROUPS == 0) ? 1 : GROUPS;
    localparam int SUB_W        = (GRP_N > 1) ? $clog2(GRP_N) : 1;
    localparam int GIX_W        = (GROUP_WIDTH > 1) ? $clog2(GROUP_WIDTH) : 1;

    // configuration registers
    logic            calib_enable_reg;
    logic            reorder_enable_reg;
    thr_mode_t       threshold_mode_reg;
    logic [15:0]     global_threshold_reg;

    // readout position counters
    logic [POS_W-1:0] pos_reg;
    logic [COL_W-1:0] col_reg;
    logic [POS_W-1:0] row_base_reg;
    logic [SUB_W-1:0] sub_reg;
    logic [COL_W-1:0] sub_base_reg;
    logic [GIX_W-1:0] grp_reg;

    // input stage
    logic                       s1_valid_reg;
    logic [COUNT_W-1:0]         s1_count_reg;
    logic [COUNT_W-1:0]         s1_thr_reg;
    logic signed [GAIN_W-1:0]   s1_gain_reg;
    logic signed [OFFSET_W-1:0] s1_offset_reg;
    logic [DEST_W-1:0]          s1_dest_reg;
    logic                       s1_last_reg;

    // result stage
    logic                       out_valid_reg;
    logic [DEST_W-1:0]          out_dest_reg;
    logic [COUNT_W-1:0]         out_count_reg;
    logic signed [ENERGY_W-1:0] out_energy_reg;
    logic                       out_last_reg;

    logic                       out_load;
    logic                       s1_load;
    logic                       in_accept;
    logic                       frame_last;
    logic                       col_last;
    logic                       sub_last;
    logic [POS_W-1:0]           mapped_pos;
    logic [POS_W-1:0]           dest_pos;
    logic                       zeroed;
    logic [COUNT_W-1:0]         count_next;
    logic signed [ENERGY_W-1:0] product;
    logic signed [ENERGY_W-1:0] energy_next;

    assign cfg_ready     = 1'b1;
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s1_load       = !s1_valid_reg || out_load;
    assign s_axis_tready = s1_load;
    assign in_accept     = s_axis_tvalid && s1_load;

    assign frame_last = (pos_reg == POS_W'(FRAME_PIXELS - 1));
    assign col_last   = (col_reg == COL_W'(FRAME_SIDE - 1));
    assign sub_last   = (sub_reg == SUB_W'(GRP_N - 1));
    assign mapped_pos = row_base_reg + POS_W'(sub_base_reg) + POS_W'(grp_reg);
    assign dest_pos   = (reorder_enable_reg && MAP_OK) ? mapped_pos : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_enable_reg     <= 1'b0;
            reorder_enable_reg   <= 1'b1;
            threshold_mode_reg   <= THR_NONE;
            global_threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CALIB_ENABLE:     calib_enable_reg     <= cfg_data[0];
                REG_REORDER_ENABLE:   reorder_enable_reg   <= cfg_data[0];
                REG_THRESHOLD_MODE:   threshold_mode_reg   <= thr_mode_t'(cfg_data[1:0]);
                REG_GLOBAL_THRESHOLD: global_threshold_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            col_reg      <= '0;
            row_base_reg <= '0;
            sub_reg      <= '0;
            sub_base_reg <= '0;
            grp_reg      <= '0;
        end
        else if (in_accept)
        begin
            if (frame_last)
            begin
                pos_reg      <= '0;
                col_reg      <= '0;
                row_base_reg <= '0;
                sub_reg      <= '0;
                sub_base_reg <= '0;
                grp_reg      <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (col_last)
                begin
                    col_reg      <= '0;
                    row_base_reg <= row_base_reg + POS_W'(FRAME_SIDE);
                    sub_reg      <= '0;
                    sub_base_reg <= '0;
                    grp_reg      <= '0;
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                    if (sub_last)
                    begin
                        sub_reg      <= '0;
                        sub_base_reg <= '0;
                        grp_reg      <= grp_reg + GIX_W'(1);
                    end
                    else
                    begin
                        sub_reg      <= sub_reg + SUB_W'(1);
                        sub_base_reg <= sub_base_reg + COL_W'(GROUP_WIDTH);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_count_reg  <= s_axis_tdata[15:0];
            s1_thr_reg    <= s_axis_tdata[31:16];
            s1_gain_reg   <= s_axis_tdata[55:32];
            s1_offset_reg <= s_axis_tdata[87:56];
            s1_dest_reg   <= DEST_W'(dest_pos);
            s1_last_reg   <= frame_last;
        end
    end

    always_comb
    begin
        case (threshold_mode_reg)
            THR_GLOBAL:    zeroed = (s1_count_reg < global_threshold_reg);
            THR_PER_PIXEL: zeroed = (s1_count_reg < s1_thr_reg);
            default:       zeroed = 1'b0;
        endcase
        count_next  = zeroed ? '0 : s1_count_reg;
        product     = ENERGY_W'($signed({1'b0, count_next})) * ENERGY_W'(s1_gain_reg);
        energy_next = calib_enable_reg ? (product + ENERGY_W'(s1_offset_reg)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_dest_reg   <= s1_dest_reg;
            out_count_reg  <= count_next;
            out_energy_reg <= energy_next;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_energy_reg, out_count_reg, out_dest_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
